FILE: design/ascii_number_stream_parser_unit_macros.svh
// Assertion macros shared by the ASCII number stream parser RTL.
`ifndef ASCII_NUMBER_STREAM_PARSER_UNIT_MACROS_SVH
`define ASCII_NUMBER_STREAM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ANP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ANP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/anp_pkg.sv
// Package with the codes, limits and digit decoder of the ASCII number stream parser.
package anp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned DIGIT_W = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_UDEC = 2'd0,
        MODE_SDEC = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_ALT  = 2'd3
    } mode_t;

    localparam logic [COUNT_W-1:0] LIMIT_SHORT = 3'd5;
    localparam logic [COUNT_W-1:0] LIMIT_LONG  = 3'd6;

    localparam logic [VALUE_W-1:0] DEC_OVF_BOUND = 16'd6553;
    localparam logic [DIGIT_W-1:0] DEC_OVF_DIGIT = 4'd5;
    localparam logic [VALUE_W-1:0] HEX_OVF_BOUND = 16'h0FFF;
    localparam logic [VALUE_W-1:0] NEG_MAG_MAX   = 16'd32768;
    localparam logic [VALUE_W-1:0] POS_MAG_MAX   = 16'd32767;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic                 valid;
        logic [DIGIT_W-1:0]   value;
    } digit_t;

    // Decodes one character as a digit of the selected base.
    function automatic digit_t decode_digit(input logic [CHAR_W-1:0] c, input logic hex);
        digit_t d;
        logic [CHAR_W-1:0] diff;
        d    = '{valid: 1'b0, value: '0};
        diff = '0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            diff = c - CH_ZERO;
            d    = '{valid: 1'b1, value: diff[DIGIT_W-1:0]};
        end else if (hex && (c inside {[CH_UA:CH_UF]})) begin
            diff = c - CH_UA + 8'd10;
            d    = '{valid: 1'b1, value: diff[DIGIT_W-1:0]};
        end else if (hex && (c inside {[CH_LA:CH_LF]})) begin
            diff = c - CH_LA + 8'd10;
            d    = '{valid: 1'b1, value: diff[DIGIT_W-1:0]};
        end
        return d;
    endfunction

endpackage

FILE: design/ascii_number_stream_parser_unit.sv
// A character is registered in the input register and parsed there once the result slot can
// take a result; the result of a character that ends a number is registered in the result register.
// Throughput: one character per cycle through the combinational parse update; a stalled result
// halts parsing, and the input stops once the input register is full as well.
// Reset (aresetn low, synchronous) empties both registers, sets mode 0 and clears the parse
// state. A write to the mode register also clears the parse state.
`include "ascii_number_stream_parser_unit_macros.svh"

module ascii_number_stream_parser_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [anp_pkg::MODE_W-1:0]            cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [anp_pkg::CHAR_W-1:0]            s_ch,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [anp_pkg::VALUE_W-1:0]           m_value,
    output logic                                  m_ok
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_LEADZ,
        PH_DIGIT
    } phase_t;

    anp_pkg::mode_t                     mode_reg;
    phase_t                             phase_reg, phase_next;
    logic [anp_pkg::COUNT_W-1:0]        char_count_reg, char_count_next;
    logic                               negative_reg, negative_next;
    logic [anp_pkg::VALUE_W-1:0]        accumulator_reg, accumulator_next;
    logic                               overflowed_reg, overflowed_next;
    logic                               seen_digit_reg, seen_digit_next;

    logic                               in_valid_reg;
    logic [anp_pkg::CHAR_W-1:0]         in_ch_reg;
    logic                               out_valid_reg;
    logic [anp_pkg::VALUE_W-1:0]        out_value_reg, out_value_next;
    logic                               out_ok_reg, out_ok_next;
    logic                               emit;

    logic                               proc_fire;
    logic                               hex;
    logic                               sgn;
    logic [anp_pkg::COUNT_W-1:0]        limit;
    logic                               do_digit;
    anp_pkg::digit_t                    dig;
    logic [anp_pkg::VALUE_W-1:0]        acc_times10;

    // The character in the input register is processed once the result slot can take a result.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    assign hex   = (mode_reg == anp_pkg::MODE_HEX);
    assign sgn   = (mode_reg == anp_pkg::MODE_SDEC);
    assign limit = (hex || sgn) ? anp_pkg::LIMIT_LONG : anp_pkg::LIMIT_SHORT;
    assign dig   = anp_pkg::decode_digit(in_ch_reg, hex);
    assign acc_times10 = {accumulator_reg[anp_pkg::VALUE_W-4:0], 3'b000}
                       + {accumulator_reg[anp_pkg::VALUE_W-2:0], 1'b0};

    always_comb begin
        phase_next       = phase_reg;
        char_count_next  = char_count_reg;
        negative_next    = negative_reg;
        accumulator_next = accumulator_reg;
        overflowed_next  = overflowed_reg;
        seen_digit_next  = seen_digit_reg;
        out_value_next   = '0;
        out_ok_next      = 1'b0;
        emit             = 1'b0;
        do_digit         = 1'b0;

        case (phase_reg)
            PH_SKIP: begin
                if (in_ch_reg == anp_pkg::CH_SPACE || in_ch_reg == anp_pkg::CH_TAB) begin
                    do_digit = 1'b0;
                end else if (sgn && (in_ch_reg == anp_pkg::CH_MINUS ||
                                     in_ch_reg == anp_pkg::CH_PLUS)) begin
                    negative_next   = (in_ch_reg == anp_pkg::CH_MINUS);
                    char_count_next = 3'd1;
                    phase_next      = PH_DIGIT;
                end else if (hex && in_ch_reg == anp_pkg::CH_ZERO) begin
                    accumulator_next = '0;
                    seen_digit_next  = 1'b1;
                    char_count_next  = 3'd1;
                    phase_next       = PH_LEADZ;
                end else begin
                    phase_next = PH_DIGIT;
                    do_digit   = 1'b1;
                end
            end
            PH_LEADZ: begin
                phase_next = PH_DIGIT;
                if (hex && (in_ch_reg == anp_pkg::CH_LX || in_ch_reg == anp_pkg::CH_UX)) begin
                    seen_digit_next  = 1'b0;
                    accumulator_next = '0;
                    char_count_next  = 3'd2;
                end else begin
                    do_digit = 1'b1;
                end
            end
            default: begin
                do_digit = 1'b1;
            end
        endcase

        if (do_digit) begin
            if (char_count_reg < limit && dig.valid) begin
                if (hex) begin
                    if (accumulator_reg > anp_pkg::HEX_OVF_BOUND) begin
                        overflowed_next = 1'b1;
                    end else begin
                        accumulator_next = {accumulator_reg[anp_pkg::VALUE_W-5:0], dig.value};
                    end
                end else begin
                    if (accumulator_reg > anp_pkg::DEC_OVF_BOUND ||
                        (accumulator_reg == anp_pkg::DEC_OVF_BOUND &&
                         dig.value > anp_pkg::DEC_OVF_DIGIT)) begin
                        overflowed_next = 1'b1;
                    end else begin
                        accumulator_next = acc_times10 + {12'd0, dig.value};
                    end
                end
                seen_digit_next = 1'b1;
                char_count_next = char_count_reg + 3'd1;
            end else begin
                // This character ends the number; the parse returns to skipping whitespace.
                emit        = 1'b1;
                out_ok_next = seen_digit_reg && !overflowed_reg;
                if (out_ok_next) begin
                    if (sgn && negative_reg) begin
                        if (accumulator_reg > anp_pkg::NEG_MAG_MAX) begin
                            out_ok_next = 1'b0;
                        end else begin
                            out_value_next = 16'd0 - accumulator_reg;
                        end
                    end else if (sgn) begin
                        if (accumulator_reg > anp_pkg::POS_MAG_MAX) begin
                            out_ok_next = 1'b0;
                        end else begin
                            out_value_next = accumulator_reg;
                        end
                    end else begin
                        out_value_next = accumulator_reg;
                    end
                end
                phase_next       = PH_SKIP;
                char_count_next  = '0;
                negative_next    = 1'b0;
                accumulator_next = '0;
                overflowed_next  = 1'b0;
                seen_digit_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= anp_pkg::MODE_UDEC;
            phase_reg       <= PH_SKIP;
            char_count_reg  <= '0;
            negative_reg    <= 1'b0;
            accumulator_reg <= '0;
            overflowed_reg  <= 1'b0;
            seen_digit_reg  <= 1'b0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                mode_reg        <= anp_pkg::mode_t'(cfg_wr_data);
                phase_reg       <= PH_SKIP;
                char_count_reg  <= '0;
                negative_reg    <= 1'b0;
                accumulator_reg <= '0;
                overflowed_reg  <= 1'b0;
                seen_digit_reg  <= 1'b0;
            end else if (proc_fire) begin
                phase_reg       <= phase_next;
                char_count_reg  <= char_count_next;
                negative_reg    <= negative_next;
                accumulator_reg <= accumulator_next;
                overflowed_reg  <= overflowed_next;
                seen_digit_reg  <= seen_digit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg <= s_ch;
        end
        if (proc_fire && emit) begin
            out_value_reg <= out_value_next;
            out_ok_reg    <= out_ok_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;
    assign m_ok    = out_ok_reg;

    `ANP_ASSERT_IMPL(a_fail_value_zero, aclk, aresetn, m_valid && !m_ok, m_value == '0,
                     "failed parse with nonzero value")
    `ANP_ASSERT_NEXT(a_cfg_clears, aclk, aresetn, cfg_wr_en,
                     phase_reg == PH_SKIP && char_count_reg == '0,
                     "mode write did not clear parse state")
    `ANP_ASSERT_IMPL(a_leadz_hex, aclk, aresetn, phase_reg == PH_LEADZ,
                     mode_reg == anp_pkg::MODE_HEX, "leading zero phase outside hex mode")
    `ANP_ASSERT_IMPL(a_count_limit, aclk, aresetn, 1'b1,
                     char_count_reg <= anp_pkg::LIMIT_LONG, "character count beyond limit")

endmodule

FILE: tb/sv/ascii_number_stream_parser_unit_tb.sv
// Self-checking testbench for the ASCII number stream parser, with a built-in parse predictor.
`timescale 1ns / 1ps

module ascii_number_stream_parser_unit_tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 250;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_CHARS   = 140;

    localparam logic [anp_pkg::CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [anp_pkg::CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [anp_pkg::CHAR_W-1:0] CH_SEMI    = 8'h3B;

    typedef enum logic [1:0] {
        ENTRY_CHAR,
        ENTRY_MODE,
        ENTRY_DRAIN
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t                kind;
        logic [anp_pkg::CHAR_W-1:0] data;
    } stream_entry_t;

    typedef struct packed {
        logic [anp_pkg::VALUE_W-1:0] value;
        logic                        ok;
    } number_t;

    typedef enum logic [1:0] {
        SCAN_SKIP,
        SCAN_LEADZ,
        SCAN_DIGITS
    } scan_phase_t;

    logic                          aclk;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [anp_pkg::MODE_W-1:0]    cfg_wr_data = anp_pkg::MODE_UDEC;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [anp_pkg::CHAR_W-1:0]    s_ch        = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [anp_pkg::VALUE_W-1:0]   m_value;
    logic                          m_ok;

    ascii_number_stream_parser_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_ok        (m_ok)
    );

    stream_entry_t char_stream[$];
    number_t       expected_numbers[$];

    // Predictor state.
    anp_pkg::mode_t              cur_mode   = anp_pkg::MODE_UDEC;
    scan_phase_t                 scan_phase = SCAN_SKIP;
    logic [anp_pkg::COUNT_W-1:0] held_chars = '0;
    logic                        neg_sign   = 1'b0;
    logic [anp_pkg::VALUE_W-1:0] acc        = '0;
    logic                        acc_ovf    = 1'b0;
    logic                        got_digit  = 1'b0;

    int  cycle_count    = 0;
    int  error_count    = 0;
    int  chars_queued   = 0;
    int  chars_accepted = 0;
    int  mode_writes    = 0;
    int  results_seen   = 0;
    int  ok_results     = 0;
    int  quiet_cycles   = 0;
    bit  offer_held     = 1'b0;
    int  burst_left     = 0;
    int  gap_left       = 0;
    int  hold_left      = 0;
    int  holds_done     = 0;
    int  pattern_age    = 0;
    logic [15:0] ready_pattern = 16'hFFFF;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic void clear_number();
        scan_phase = SCAN_SKIP;
        held_chars = '0;
        neg_sign   = 1'b0;
        acc        = '0;
        acc_ovf    = 1'b0;
        got_digit  = 1'b0;
    endfunction

    // Advances the parse by one character and queues a result when a number ends.
    function automatic void parse_char(input logic [anp_pkg::CHAR_W-1:0] c);
        logic                        hex;
        logic [anp_pkg::COUNT_W-1:0] lim;
        logic                        is_digit;
        logic [anp_pkg::DIGIT_W-1:0] dval;
        logic [31:0]                 wide;
        number_t                     res;
        hex  = (cur_mode == anp_pkg::MODE_HEX);
        lim  = (cur_mode == anp_pkg::MODE_SDEC || hex) ? anp_pkg::LIMIT_LONG
                                                       : anp_pkg::LIMIT_SHORT;
        wide = '0;
        dval = '0;
        if (scan_phase == SCAN_SKIP) begin
            if (c == anp_pkg::CH_SPACE || c == anp_pkg::CH_TAB) return;
            if (cur_mode == anp_pkg::MODE_SDEC &&
                (c == anp_pkg::CH_MINUS || c == anp_pkg::CH_PLUS)) begin
                neg_sign   = (c == anp_pkg::CH_MINUS);
                held_chars = 3'd1;
                scan_phase = SCAN_DIGITS;
                return;
            end
            if (hex && c == anp_pkg::CH_ZERO) begin
                acc        = '0;
                got_digit  = 1'b1;
                held_chars = 3'd1;
                scan_phase = SCAN_LEADZ;
                return;
            end
            scan_phase = SCAN_DIGITS;
        end else if (scan_phase == SCAN_LEADZ) begin
            scan_phase = SCAN_DIGITS;
            // A zero followed by x turns out to be a prefix, not a digit.
            if (hex && (c == anp_pkg::CH_LX || c == anp_pkg::CH_UX)) begin
                got_digit  = 1'b0;
                acc        = '0;
                held_chars = 3'd2;
                return;
            end
        end

        is_digit = 1'b1;
        if (c >= anp_pkg::CH_ZERO && c <= anp_pkg::CH_NINE)
            dval = 4'(c - anp_pkg::CH_ZERO);
        else if (hex && c >= anp_pkg::CH_UA && c <= anp_pkg::CH_UF)
            dval = 4'(c - anp_pkg::CH_UA + 8'd10);
        else if (hex && c >= anp_pkg::CH_LA && c <= anp_pkg::CH_LF)
            dval = 4'(c - anp_pkg::CH_LA + 8'd10);
        else
            is_digit = 1'b0;

        if (held_chars < lim && is_digit) begin
            if (hex) begin
                if (acc > anp_pkg::HEX_OVF_BOUND) acc_ovf = 1'b1;
                else acc = {acc[anp_pkg::VALUE_W-5:0], dval};
            end else begin
                if (acc > anp_pkg::DEC_OVF_BOUND ||
                    (acc == anp_pkg::DEC_OVF_BOUND && dval > anp_pkg::DEC_OVF_DIGIT))
                    acc_ovf = 1'b1;
                else begin
                    wide = 32'(acc) * 32'd10 + 32'(dval);
                    acc  = wide[anp_pkg::VALUE_W-1:0];
                end
            end
            got_digit  = 1'b1;
            held_chars = held_chars + 3'd1;
            return;
        end

        // Anything else ends the number and is swallowed with it.
        res.ok    = got_digit && !acc_ovf;
        res.value = '0;
        if (res.ok) begin
            if (cur_mode == anp_pkg::MODE_SDEC) begin
                if (neg_sign) begin
                    if (acc > anp_pkg::NEG_MAG_MAX) res.ok = 1'b0;
                    else res.value = 16'd0 - acc;
                end else begin
                    if (acc > anp_pkg::POS_MAG_MAX) res.ok = 1'b0;
                    else res.value = acc;
                end
            end else begin
                res.value = acc;
            end
        end
        if (!res.ok) res.value = '0;
        clear_number();
        expected_numbers.push_back(res);
    endfunction

    // Stimulus construction.
    task automatic add_char(input logic [anp_pkg::CHAR_W-1:0] c);
        char_stream.push_back('{kind: ENTRY_CHAR, data: c});
        chars_queued++;
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) add_char(txt[i]);
    endtask

    task automatic add_mode(input anp_pkg::mode_t m);
        char_stream.push_back('{kind: ENTRY_MODE, data: {6'd0, m}});
    endtask

    function automatic logic [anp_pkg::CHAR_W-1:0] random_digit(input anp_pkg::mode_t m);
        int pick;
        if (m != anp_pkg::MODE_HEX) return anp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        pick = $urandom_range(0, 21);
        if (pick < 10) return anp_pkg::CH_ZERO + 8'(pick);
        if (pick < 16) return anp_pkg::CH_UA + 8'(pick - 10);
        return anp_pkg::CH_LA + 8'(pick - 16);
    endfunction

    task automatic add_random_number(input anp_pkg::mode_t m);
        int    body_max;
        int    v;
        int    n;
        string digits;
        if ($urandom_range(0, 9) == 0) begin
            // Raw noise: any byte at all.
            repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2))
                add_char($urandom_range(0, 1) ? anp_pkg::CH_SPACE : anp_pkg::CH_TAB);
            body_max = (m == anp_pkg::MODE_SDEC || m == anp_pkg::MODE_HEX) ? 6 : 5;
            if (m == anp_pkg::MODE_SDEC && $urandom_range(0, 2) != 0) begin
                add_char($urandom_range(0, 1) ? anp_pkg::CH_MINUS : anp_pkg::CH_PLUS);
                body_max--;
            end else if (m == anp_pkg::MODE_HEX && $urandom_range(0, 2) == 0) begin
                add_char(anp_pkg::CH_ZERO);
                add_char($urandom_range(0, 1) ? anp_pkg::CH_LX : anp_pkg::CH_UX);
                body_max -= 2;
            end
            if ($urandom_range(0, 9) < 4) begin
                case ($urandom_range(0, 7))
                    0:       v = 0;
                    1:       v = 32767 + $urandom_range(0, 2);
                    2:       v = 65530 + $urandom_range(0, 9);
                    3:       v = 6550 + $urandom_range(0, 9);
                    4:       v = 4094 + $urandom_range(0, 3);
                    5:       v = $urandom_range(0, 99);
                    default: v = $urandom_range(0, 65535);
                endcase
                digits = (m == anp_pkg::MODE_HEX) ? $sformatf("%0h", v) : $sformatf("%0d", v);
                if ($urandom_range(0, 1)) digits = digits.toupper();
                add_text(digits);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, body_max);
                repeat (n) add_char(random_digit(m));
            end
            case ($urandom_range(0, 9))
                0, 1, 2: add_char(anp_pkg::CH_SPACE);
                3:       add_char(anp_pkg::CH_TAB);
                4:       add_char(CH_NEWLINE);
                5:       add_char(CH_COMMA);
                6:       add_char(CH_SEMI);
                7, 8:    add_char(8'($urandom_range(0, 255)));
                default: ; // Runs straight into the next number.
            endcase
        end
    endtask

    initial begin
        anp_pkg::mode_t m;
        int             phase_start;

        // Directed: unsigned decimal straight out of reset.
        add_text(" \t0 ");
        add_text("65535");
        add_char(8'hFF);
        add_text("65536 -12a");
        // Signed decimal, range edges, bare sign and a mode write in the middle of a number.
        add_mode(anp_pkg::MODE_SDEC);
        add_text("-32768 +32767 -32769 32768 -0 + 12");
        add_mode(anp_pkg::MODE_SDEC);
        add_text("3");
        add_char(8'h00);
        // Hexadecimal: prefix handling, overflow and a full buffer.
        add_mode(anp_pkg::MODE_HEX);
        add_text("0x 0 0xFFFF fFfF0 0XaB1 fffff10 0x12345 ");
        // The spare mode code parses as unsigned decimal.
        add_mode(anp_pkg::MODE_ALT);
        add_text("99 -7 ");

        for (int p = 0; p < PHASE_COUNT; p++) begin
            m = (p < 4) ? anp_pkg::mode_t'(p) : anp_pkg::mode_t'($urandom_range(0, 3));
            add_mode(m);
            phase_start = chars_queued;
            while (chars_queued - phase_start < PHASE_CHARS) begin
                add_random_number(m);
                if (p == 6 && chars_queued - phase_start >= PHASE_CHARS / 2 &&
                    char_stream[$].kind == ENTRY_CHAR && $urandom_range(0, 7) == 0)
                    char_stream.push_back('{kind: ENTRY_DRAIN, data: '0});
            end
        end
        char_stream.push_back('{kind: ENTRY_DRAIN, data: '0});

        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (char_stream.size() != 0 || offer_held) @(posedge aclk);
        while (expected_numbers.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_numbers.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_numbers.size()));

        $display("Sent %0d characters under %0d mode writes in all four modes.",
                 chars_accepted, mode_writes);
        $display("Checked %0d parsed numbers, %0d of them ok; %0d errors.",
                 results_seen, ok_results, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Input side: characters go out in bursts; mode writes and drains wait for the block to idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else if (!offer_held) begin
            if (char_stream.size() == 0) begin
                s_valid   <= 1'b0;
                cfg_wr_en <= 1'b0;
            end else begin
                case (char_stream[0].kind)
                    ENTRY_CHAR: begin
                        cfg_wr_en <= 1'b0;
                        if (gap_left > 0) begin
                            gap_left--;
                            s_valid <= 1'b0;
                        end else begin
                            s_valid    <= 1'b1;
                            s_ch       <= char_stream[0].data;
                            offer_held = 1'b1;
                            if (burst_left > 1) begin
                                burst_left--;
                            end else begin
                                burst_left = $urandom_range(1, 40);
                                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                            end
                        end
                    end
                    ENTRY_MODE: begin
                        s_valid <= 1'b0;
                        if (expected_numbers.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                            cfg_wr_en   <= 1'b1;
                            cfg_wr_data <= char_stream[0].data[anp_pkg::MODE_W-1:0];
                            cur_mode    = anp_pkg::mode_t'(char_stream[0].data[anp_pkg::MODE_W-1:0]);
                            clear_number();
                            mode_writes++;
                            void'(char_stream.pop_front());
                        end else begin
                            cfg_wr_en <= 1'b0;
                        end
                    end
                    default: begin
                        s_valid   <= 1'b0;
                        cfg_wr_en <= 1'b0;
                        if (expected_numbers.size() == 0) void'(char_stream.pop_front());
                    end
                endcase
            end
        end
    end

    // A character transaction updates the prediction as it is accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                void'(char_stream.pop_front());
                offer_held = 1'b0;
                parse_char(s_ch);
                chars_accepted++;
                quiet_cycles = 0;
            end else if (quiet_cycles < 1000) begin
                quiet_cycles++;
            end
        end
    end

    // Output side: a rotating stall pattern, plus two long hold-offs that back the block up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if ((holds_done == 0 && chars_accepted >= 300) ||
                     (holds_done == 1 && chars_accepted >= 1100)) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'($urandom & $urandom);
                    default: ready_pattern = 16'($urandom | $urandom);
                endcase
                if (ready_pattern == '0) ready_pattern = 16'h0001;
                pattern_age = 48;
            end
            pattern_age--;
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            m_ready <= ready_pattern[0];
        end
    end

    always @(posedge aclk) begin
        number_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_ok) ok_results++;
            if (expected_numbers.size() == 0) begin
                flag_error($sformatf("unexpected result value %h ok %b", m_value, m_ok));
            end else begin
                want = expected_numbers.pop_front();
                if (m_value !== want.value || m_ok !== want.ok)
                    flag_error($sformatf("result %0d: expected value %h ok %b, got value %h ok %b",
                                         results_seen, want.value, want.ok, m_value, m_ok));
            end
        end
    end

endmodule

FILE: ascii_number_stream_parser_unit.f
+incdir+design
design/anp_pkg.sv
design/ascii_number_stream_parser_unit.sv
tb/sv/ascii_number_stream_parser_unit_tb.sv
